// ===== rtl/core/fge_pkg.sv =====
`default_nettype none

package fge_pkg;

    // Bitmap byte and field widths
    localparam int BYTE_BITS    = 8;
    localparam int ORIGIN_W     = 9;
    localparam int COORD_W      = 10;
    localparam int PIX_COLOR_W  = 18;
    localparam int SIDE_REG_W   = 6;
    localparam int CLIP_W       = 16;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int LANE_IDX_W   = 3;
    localparam int COUNT_W      = 4;

    // Register reset values
    localparam logic [SIDE_REG_W-1:0] RST_GLYPH_W   = 6'd8;
    localparam logic [SIDE_REG_W-1:0] RST_GLYPH_H   = 6'd16;
    localparam logic [CFG_DATA_W-1:0] RST_CLIP_LT   = 32'd0;
    localparam logic [CFG_DATA_W-1:0] RST_CLIP_RB   = 32'd15729000;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLYPH_WIDTH  = 3'd0,
        CFG_GLYPH_HEIGHT = 3'd1,
        CFG_FORE_COLOR   = 3'd2,
        CFG_BACK_COLOR   = 3'd3,
        CFG_RIGHT_ALIGN  = 3'd4,
        CFG_CLIP_LT      = 3'd5,
        CFG_CLIP_RB      = 3'd6
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/core/font_glyph_expander.sv =====
`default_nettype none

// Font glyph expander.
// Three channels, each valid/ready: a configuration write channel (register
// index and data, always ready), an input channel of font bytes with a
// glyph-start flag and origin, and an output channel of pixels (x, y, color,
// foreground flag, last-of-byte flag).
// Each accepted byte updates the row/column counters in the accept cycle and
// loads up to eight visible pixels into a job register; the job register
// feeds one pixel per cycle, while the receiver is ready, into the output
// register, so a byte's first pixel passes through the job register and then
// the output register. The visible pixels leave one at a time through the
// single-pixel output register; a byte with no visible pixel loads no job.
// A new byte is accepted in the same cycle the last pixel of the previous
// byte moves to the output register, so bytes flow back to back.
// Reset restores the register defaults (8x16 glyph, white on black, clip
// window 360x240) and drops any glyph in progress. When the receiver stalls,
// the output register holds its pixel, the job register holds the rest, and
// input ready drops once the job register is still occupied.

module font_glyph_expander #(
    parameter int MAX_GLYPH_SIDE = 32,
    parameter int COLOR_BITS     = 18
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration writes
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [fge_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [fge_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // font byte requests
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire  [fge_pkg::BYTE_BITS-1:0]     i_font_byte,
    input  wire                               i_glyph_start,
    input  wire  [fge_pkg::ORIGIN_W-1:0]      i_origin_x,
    input  wire  [fge_pkg::ORIGIN_W-1:0]      i_origin_y,
    // pixel results
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [fge_pkg::COORD_W-1:0]       o_pixel_x,
    output logic [fge_pkg::COORD_W-1:0]       o_pixel_y,
    output logic [fge_pkg::PIX_COLOR_W-1:0]   o_pixel_color,
    output logic                              o_is_foreground,
    output logic                              o_last
);

    localparam int SW = $clog2(MAX_GLYPH_SIDE + 1);
    localparam int CW = (COLOR_BITS < fge_pkg::PIX_COLOR_W) ? COLOR_BITS
                                                            : fge_pkg::PIX_COLOR_W;
    localparam int NB = fge_pkg::BYTE_BITS;
    localparam int XW = fge_pkg::COORD_W;

    // configuration registers
    logic [fge_pkg::SIDE_REG_W-1:0] r_glyph_w, r_glyph_h;
    logic [CW-1:0]                  r_fore, r_back;
    logic                           r_right;
    logic [fge_pkg::CFG_DATA_W-1:0] r_clip_lt, r_clip_rb;

    // glyph walk state
    logic [SW-1:0]                  r_col, r_row, n_col, n_row;
    logic [fge_pkg::ORIGIN_W-1:0]   r_org_x, r_org_y, n_org_x, n_org_y;
    logic                           r_active, n_active;

    // job register: pixels of one byte still to be sent
    logic                           r_job_valid;
    logic [NB-1:0]                  r_mask, r_bits, n_mask, n_bits;
    logic [XW-1:0]                  r_base_x, r_y, n_base_x, n_y;

    // output register
    logic                           r_out_valid;
    logic [XW-1:0]                  r_out_x, r_out_y;
    logic [fge_pkg::PIX_COLOR_W-1:0] r_out_color;
    logic                           r_out_fg, r_out_last;

    logic                           in_acc, emit, job_last;
    logic [fge_pkg::LANE_IDX_W-1:0] lane;
    logic [NB-1:0]                  mask_rest;

    logic [SW-1:0]                  w_eff, h_eff, col_eff, rem, col_sum;
    logic [fge_pkg::ORIGIN_W-1:0]   org_x, org_y;
    logic                           act_eff;
    logic [fge_pkg::LANE_IDX_W-1:0] skip;
    logic [fge_pkg::COUNT_W-1:0]    avail, count;
    logic [NB-1:0]                  byte_al;
    logic [XW-1:0]                  x_i;
    logic [fge_pkg::CLIP_W-1:0]     cl, ct, cr, cb;
    logic                           y_in;

    assign o_cfg_ready = 1'b1;

    assign cl = r_clip_lt[fge_pkg::CLIP_W-1:0];
    assign ct = r_clip_lt[fge_pkg::CFG_DATA_W-1:fge_pkg::CLIP_W];
    assign cr = r_clip_rb[fge_pkg::CLIP_W-1:0];
    assign cb = r_clip_rb[fge_pkg::CFG_DATA_W-1:fge_pkg::CLIP_W];

    // clamp glyph sides to 1..MAX_GLYPH_SIDE
    always_comb begin
        if (r_glyph_w == '0) begin
            w_eff = SW'(1);
        end else if (8'(r_glyph_w) > 8'(MAX_GLYPH_SIDE)) begin
            w_eff = SW'(MAX_GLYPH_SIDE);
        end else begin
            w_eff = SW'(r_glyph_w);
        end
        if (r_glyph_h == '0) begin
            h_eff = SW'(1);
        end else if (8'(r_glyph_h) > 8'(MAX_GLYPH_SIDE)) begin
            h_eff = SW'(MAX_GLYPH_SIDE);
        end else begin
            h_eff = SW'(r_glyph_h);
        end
    end

    // pick lowest pending pixel of the job
    always_comb begin
        lane = '0;
        for (int i = NB - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                lane = fge_pkg::LANE_IDX_W'(i);
            end
        end
    end

    assign mask_rest = r_mask & ~(NB'(1) << lane);
    assign job_last  = (mask_rest == '0);
    assign emit      = r_job_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_job_valid || (emit && job_last);
    assign in_acc    = i_valid && o_ready;

    // per-byte decode: counters, alignment, clip mask
    always_comb begin
        org_x   = i_glyph_start ? i_origin_x : r_org_x;
        org_y   = i_glyph_start ? i_origin_y : r_org_y;
        act_eff = i_glyph_start || r_active;
        if (i_glyph_start) begin
            col_eff = '0;
            n_row   = '0;
        end else begin
            col_eff = (r_col >= w_eff) ? '0 : r_col;
            n_row   = r_row;
        end

        // leading pad bits in right-aligned mode: (-w) mod 8
        skip = '0;
        if (r_right && col_eff == '0) begin
            skip = fge_pkg::LANE_IDX_W'(~w_eff[fge_pkg::LANE_IDX_W-1:0] + 1'b1);
        end
        avail = fge_pkg::COUNT_W'(NB) - fge_pkg::COUNT_W'(skip);
        rem   = w_eff - col_eff;
        count = (8'(rem) < 8'(avail)) ? fge_pkg::COUNT_W'(rem) : avail;

        byte_al  = i_font_byte << skip;
        n_base_x = XW'(org_x) + XW'(col_eff);
        n_y      = XW'(org_y) + XW'(n_row);
        y_in     = (fge_pkg::CLIP_W'(n_y) >= ct) && (fge_pkg::CLIP_W'(n_y) < cb);

        n_mask = '0;
        n_bits = '0;
        for (int i = 0; i < NB; i++) begin
            x_i       = n_base_x + XW'(i);
            n_bits[i] = byte_al[NB-1-i];
            n_mask[i] = act_eff && (fge_pkg::COUNT_W'(i) < count) && y_in
                        && (fge_pkg::CLIP_W'(x_i) >= cl) && (fge_pkg::CLIP_W'(x_i) < cr);
        end

        // advance column and row
        col_sum  = col_eff + SW'(count);
        n_col    = col_sum;
        n_active = act_eff;
        n_org_x  = org_x;
        n_org_y  = org_y;
        if (!act_eff) begin
            n_col = r_col;
        end else if (col_sum >= w_eff) begin
            n_col = '0;
            n_row = n_row + 1'b1;
            if (n_row >= h_eff) begin
                n_row    = '0;
                n_active = 1'b0;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_w   <= fge_pkg::RST_GLYPH_W;
            r_glyph_h   <= fge_pkg::RST_GLYPH_H;
            r_fore      <= '1;
            r_back      <= '0;
            r_right     <= 1'b0;
            r_clip_lt   <= fge_pkg::RST_CLIP_LT;
            r_clip_rb   <= fge_pkg::RST_CLIP_RB;
            r_col       <= '0;
            r_row       <= '0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_active    <= 1'b0;
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                case (fge_pkg::t_cfg_idx'(i_cfg_index))
                    fge_pkg::CFG_GLYPH_WIDTH:
                        r_glyph_w <= i_cfg_data[fge_pkg::SIDE_REG_W-1:0];
                    fge_pkg::CFG_GLYPH_HEIGHT:
                        r_glyph_h <= i_cfg_data[fge_pkg::SIDE_REG_W-1:0];
                    fge_pkg::CFG_FORE_COLOR:  r_fore    <= i_cfg_data[CW-1:0];
                    fge_pkg::CFG_BACK_COLOR:  r_back    <= i_cfg_data[CW-1:0];
                    fge_pkg::CFG_RIGHT_ALIGN: r_right   <= i_cfg_data[0];
                    fge_pkg::CFG_CLIP_LT:     r_clip_lt <= i_cfg_data;
                    fge_pkg::CFG_CLIP_RB:     r_clip_rb <= i_cfg_data;
                    default: ;
                endcase
            end

            // output register
            if (emit) begin
                r_out_valid <= 1'b1;
                r_out_x     <= r_base_x + XW'(lane);
                r_out_y     <= r_y;
                r_out_fg    <= r_bits[lane];
                r_out_color <= fge_pkg::PIX_COLOR_W'(r_bits[lane] ? r_fore : r_back);
                r_out_last  <= job_last;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            // job register: load a new byte, or retire the pixel just sent
            if (in_acc && n_mask != '0) begin
                r_job_valid <= 1'b1;
                r_mask      <= n_mask;
                r_bits      <= n_bits;
                r_base_x    <= n_base_x;
                r_y         <= n_y;
            end else if (emit) begin
                r_mask <= mask_rest;
                if (job_last) begin
                    r_job_valid <= 1'b0;
                end
            end

            // accept a font byte
            if (in_acc) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_org_x  <= n_org_x;
                r_org_y  <= n_org_y;
                r_active <= n_active;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_x       = r_out_x;
    assign o_pixel_y       = r_out_y;
    assign o_pixel_color   = r_out_color;
    assign o_is_foreground = r_out_fg;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire
